// File: rtl/mmps_pkg.sv
// Shared types and constants for the mask map point suppression block.
// Holds map geometry, memory banking, action codes and beat structs.
// No dependencies.
package mmps_pkg;

	localparam int MAX_MAP_WIDTH  = 128;
	localparam int MAX_MAP_HEIGHT = 128;
	localparam int MAP_CELLS      = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
	localparam int ADDR_W         = $clog2(MAP_CELLS);

	localparam int CELL_W      = 8;
	localparam int COORD_W     = 7;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int PROD_W      = 16;

	localparam int WORD_BYTES  = 32;
	localparam int OFF_W       = $clog2(WORD_BYTES);
	localparam int BANK_AW     = ADDR_W - OFF_W - 1;
	localparam int BANK_DEPTH  = MAP_CELLS / (2 * WORD_BYTES);

	localparam int WIN_SIZE    = 17;
	localparam int WIN_HALF    = 8;
	localparam int ROW_CNT_W   = $clog2(WIN_SIZE);

	localparam logic [CELL_W-1:0] KEPT_MARK = 8'd255;
	localparam logic [CELL_W-1:0] CANDIDATE = 8'd1;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 8'd128;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 8'd128;

	localparam logic [1:0] ACT_WRITE    = 2'd0;
	localparam logic [1:0] ACT_SUPPRESS = 2'd1;
	localparam logic [1:0] ACT_READ     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;

	typedef struct packed {
		logic [1:0]         action;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [CELL_W-1:0]  cell_value;
		logic               final_point;
	} item_t;

	typedef struct packed {
		logic [CELL_W-1:0] read_value;
		logic              kept;
		logic              status;
		logic              list_done;
	} result_t;

endpackage

// File: rtl/mask_map_point_suppression_core.sv
// Top level of the mask map point suppression block: FSM, config registers
// and the two banks of 32-byte mask words. Depends on mmps_pkg.
//
// Usage: items enter on item/item_valid/item_ready and each gives exactly one
// result beat on result/result_valid/result_ready. Config registers are
// written through cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle; the block itself does not enforce this. The map lives
// in two banks of 32-byte words with byte enables; even words sit in bank 0,
// odd words in bank 1, so a 17-cell window row (which spans at most two
// neighboring words) is cleared per cycle. From accept to result: an item
// outside the map passes CALC then DONE, a write CALC, WRITE and DONE, a read
// or a suppress whose centre is no candidate CALC, READ, CHECK and DONE, and
// a kept suppress also WIPE (17 row clears) and MARK (centre mark) first.
// The block returns to idle before the next beat is taken.
// After reset the block sweeps both banks to zero, one word per bank per
// cycle over all 256 words with item_ready low; config writes are still taken.
// A finished result sits in an output register: the block takes the next
// beat while it waits, and holds the following result until the receiver
// takes the pending one.
module mask_map_point_suppression_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  mmps_pkg::item_t                    item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output mmps_pkg::result_t                  result,
	input  logic                               cfg_we,
	input  logic [mmps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmps_pkg::CFG_W-1:0]         cfg_data
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CALC, ST_WRITE, ST_READ,
		ST_CHECK, ST_WIPE, ST_MARK, ST_DONE
	} state_t;

	typedef logic [mmps_pkg::WORD_BYTES-1:0][mmps_pkg::CELL_W-1:0] word_t;

	state_t                               state_q;
	logic [mmps_pkg::BANK_AW-1:0]         clear_cnt_q;
	logic [mmps_pkg::CFG_W-1:0]           map_width_q;
	logic [mmps_pkg::CFG_W-1:0]           map_height_q;
	mmps_pkg::item_t                      item_q;
	mmps_pkg::result_t                    res_q;
	mmps_pkg::result_t                    result_q;
	logic                                 result_valid_q;
	logic [mmps_pkg::ADDR_W-1:0]          base_q;
	logic [mmps_pkg::ADDR_W-1:0]          ctr_q;
	logic [mmps_pkg::ADDR_W-1:0]          wipe_addr_q;
	logic [mmps_pkg::ROW_CNT_W-1:0]       wipe_row_q;

	logic [mmps_pkg::CFG_W-1:0]           eff_w;
	logic [mmps_pkg::CFG_W-1:0]           eff_h;
	logic [mmps_pkg::PROD_W-1:0]          base_full;
	logic [mmps_pkg::PROD_W-1:0]          ctr_full;
	logic                                 cell_ok;
	logic                                 win_ok;

	logic [mmps_pkg::ADDR_W-1:0]          rd_addr;
	logic [mmps_pkg::BANK_AW-1:0]         rd_bank_addr;
	word_t                                rdata0_s1;
	word_t                                rdata1_s1;
	word_t                                rd_word;
	logic [mmps_pkg::CELL_W-1:0]          rd_byte;

	logic [mmps_pkg::ADDR_W-1:0]          byte_addr;
	logic [2*mmps_pkg::WORD_BYTES-1:0]    span;
	logic                                 wipe_bank;
	logic [mmps_pkg::BANK_AW-1:0]         wipe_word;
	logic [1:0]                           bank_we;
	logic [1:0][mmps_pkg::WORD_BYTES-1:0] bank_be;
	logic [1:0][mmps_pkg::BANK_AW-1:0]    bank_waddr;
	logic [mmps_pkg::CELL_W-1:0]          wbyte;

	word_t mem0 [mmps_pkg::BANK_DEPTH];
	word_t mem1 [mmps_pkg::BANK_DEPTH];

	assign eff_w = (int'(map_width_q) > mmps_pkg::MAX_MAP_WIDTH) ?
		mmps_pkg::CFG_W'(mmps_pkg::MAX_MAP_WIDTH) : map_width_q;
	assign eff_h = (int'(map_height_q) > mmps_pkg::MAX_MAP_HEIGHT) ?
		mmps_pkg::CFG_W'(mmps_pkg::MAX_MAP_HEIGHT) : map_height_q;

	assign base_full = mmps_pkg::PROD_W'(item_q.row) * mmps_pkg::PROD_W'(eff_w)
		+ mmps_pkg::PROD_W'(item_q.col);
	assign ctr_full = (mmps_pkg::PROD_W'(item_q.row) + mmps_pkg::PROD_W'(mmps_pkg::WIN_HALF))
		* mmps_pkg::PROD_W'(eff_w) + mmps_pkg::PROD_W'(item_q.col)
		+ mmps_pkg::PROD_W'(mmps_pkg::WIN_HALF);

	assign cell_ok = (mmps_pkg::CFG_W'(item_q.col) < eff_w)
		&& (mmps_pkg::CFG_W'(item_q.row) < eff_h);
	assign win_ok = ((9'(item_q.col) + 9'(mmps_pkg::WIN_SIZE)) <= 9'(eff_w))
		&& ((9'(item_q.row) + 9'(mmps_pkg::WIN_SIZE)) <= 9'(eff_h));

	assign rd_addr      = (item_q.action == mmps_pkg::ACT_SUPPRESS) ? ctr_q : base_q;
	assign rd_bank_addr = rd_addr[mmps_pkg::ADDR_W-1:mmps_pkg::OFF_W+1];
	assign rd_word      = rd_addr[mmps_pkg::OFF_W] ? rdata1_s1 : rdata0_s1;
	assign rd_byte      = rd_word[rd_addr[mmps_pkg::OFF_W-1:0]];

	assign byte_addr = (state_q == ST_MARK) ? ctr_q : base_q;
	assign span = (2*mmps_pkg::WORD_BYTES)'((64'd1 << mmps_pkg::WIN_SIZE) - 64'd1)
		<< wipe_addr_q[mmps_pkg::OFF_W-1:0];
	assign wipe_bank = wipe_addr_q[mmps_pkg::OFF_W];
	assign wipe_word = wipe_addr_q[mmps_pkg::ADDR_W-1:mmps_pkg::OFF_W+1];

	always_comb begin
		bank_we    = '0;
		bank_be    = '0;
		bank_waddr = '0;
		wbyte      = '0;
		case (state_q)
			ST_CLEAR: begin
				bank_we    = 2'b11;
				bank_be    = '1;
				bank_waddr = {clear_cnt_q, clear_cnt_q};
			end
			ST_WRITE, ST_MARK: begin
				bank_we[byte_addr[mmps_pkg::OFF_W]]    = 1'b1;
				bank_be[byte_addr[mmps_pkg::OFF_W]]    = mmps_pkg::WORD_BYTES'(1)
					<< byte_addr[mmps_pkg::OFF_W-1:0];
				bank_waddr[byte_addr[mmps_pkg::OFF_W]] =
					byte_addr[mmps_pkg::ADDR_W-1:mmps_pkg::OFF_W+1];
				wbyte = (state_q == ST_MARK) ? mmps_pkg::KEPT_MARK : item_q.cell_value;
			end
			ST_WIPE: begin
				bank_we[wipe_bank]     = 1'b1;
				bank_be[wipe_bank]     = span[mmps_pkg::WORD_BYTES-1:0];
				bank_waddr[wipe_bank]  = wipe_word;
				bank_we[~wipe_bank]    = |span[2*mmps_pkg::WORD_BYTES-1:mmps_pkg::WORD_BYTES];
				bank_be[~wipe_bank]    = span[2*mmps_pkg::WORD_BYTES-1:mmps_pkg::WORD_BYTES];
				bank_waddr[~wipe_bank] = wipe_word + mmps_pkg::BANK_AW'(wipe_bank);
			end
			default: begin
				bank_we = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < mmps_pkg::WORD_BYTES; i++) begin
			if (bank_we[0] && bank_be[0][i]) begin
				mem0[bank_waddr[0]][i] <= wbyte;
			end
		end
		rdata0_s1 <= mem0[rd_bank_addr];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < mmps_pkg::WORD_BYTES; i++) begin
			if (bank_we[1] && bank_be[1][i]) begin
				mem1[bank_waddr[1]][i] <= wbyte;
			end
		end
		rdata1_s1 <= mem1[rd_bank_addr];
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clear_cnt_q    <= '0;
			map_width_q    <= mmps_pkg::RESET_WIDTH;
			map_height_q   <= mmps_pkg::RESET_HEIGHT;
			item_q         <= '0;
			res_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
			base_q         <= '0;
			ctr_q          <= '0;
			wipe_addr_q    <= '0;
			wipe_row_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mmps_pkg::REG_MAP_WIDTH:  map_width_q  <= cfg_data;
					mmps_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clear_cnt_q <= clear_cnt_q + 1'b1;
					if (&clear_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						item_q  <= item;
						res_q   <= mmps_pkg::result_t'{read_value: '0, kept: 1'b0,
							status: 1'b0, list_done: item.final_point};
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					base_q      <= mmps_pkg::ADDR_W'(base_full);
					ctr_q       <= mmps_pkg::ADDR_W'(ctr_full);
					wipe_addr_q <= mmps_pkg::ADDR_W'(base_full);
					wipe_row_q  <= '0;
					case (item_q.action)
						mmps_pkg::ACT_WRITE: begin
							res_q.status <= !cell_ok;
							state_q      <= cell_ok ? ST_WRITE : ST_DONE;
						end
						mmps_pkg::ACT_READ: begin
							res_q.status <= !cell_ok;
							state_q      <= cell_ok ? ST_READ : ST_DONE;
						end
						mmps_pkg::ACT_SUPPRESS: begin
							res_q.status <= !win_ok;
							state_q      <= win_ok ? ST_READ : ST_DONE;
						end
						default: begin
							res_q.status <= 1'b1;
							state_q      <= ST_DONE;
						end
					endcase
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (item_q.action == mmps_pkg::ACT_READ) begin
						res_q.read_value <= rd_byte;
						state_q          <= ST_DONE;
					end else if (rd_byte == mmps_pkg::CANDIDATE) begin
						state_q <= ST_WIPE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WIPE: begin
					wipe_addr_q <= wipe_addr_q + mmps_pkg::ADDR_W'(eff_w);
					wipe_row_q  <= wipe_row_q + 1'b1;
					if (wipe_row_q == mmps_pkg::ROW_CNT_W'(mmps_pkg::WIN_SIZE - 1)) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					res_q.kept <= 1'b1;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_valid_q || result_ready) begin
						result_q <= res_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_starts_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == ST_CALC))
		else $error("accepted beat did not start address calculation");

	a_kept_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.kept && result.status))
		else $error("kept point flagged as outside map");

	a_wipe_rows_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WIPE) |-> (wipe_row_q < mmps_pkg::ROW_CNT_W'(mmps_pkg::WIN_SIZE)))
		else $error("window clear ran past its last row");

	a_mark_after_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> $past(state_q == ST_WIPE))
		else $error("centre marked without a full window clear");

endmodule
